/* hdl/gtpk_pkg.sv */
// Shared constants, types and packing widths for the genotype two-bit packer.
package gtpk_pkg;

   localparam int MAX_SAMPLES = 65536;

   localparam int ALLELE_W   = 9;
   localparam int SLOT_W     = 4;
   localparam int WORD_W     = 32;
   localparam int CODE_W     = 2;
   localparam int STAT_W     = 18;
   localparam int LZ_W       = 6;

   localparam int FIELD18_MAX      = 262143;
   localparam int SUM_LIMIT_RAW    = 3 * MAX_SAMPLES;
   localparam int PREFIX_LIMIT_RAW = ((MAX_SAMPLES + 15) / 16) * 32;
   localparam int SUM_LIMIT    = (SUM_LIMIT_RAW < FIELD18_MAX) ? SUM_LIMIT_RAW : FIELD18_MAX;
   localparam int PREFIX_LIMIT =
      (PREFIX_LIMIT_RAW < FIELD18_MAX) ? PREFIX_LIMIT_RAW : FIELD18_MAX;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 72;

   // Allele index value that marks a missing call.
   localparam logic signed [ALLELE_W-1:0] ALLELE_MISSING = -9'sd1;

   typedef enum logic [CODE_W-1:0] {
      CODE_REF     = 2'd0,
      CODE_HET     = 2'd1,
      CODE_HOM_ALT = 2'd2,
      CODE_MISSING = 2'd3
   } gt_code_type;

endpackage

/* hdl/gtpk_classify.sv */
// Classifies one sample's allele pair into a two-bit genotype code.
module gtpk_classify
   import gtpk_pkg::*;
(
   input  logic signed [ALLELE_W-1:0] first_allele,
   input  logic                       has_second,
   input  logic signed [ALLELE_W-1:0] second_allele,
   output gt_code_type                code
);

   logic first_missing;
   logic second_missing;
   logic first_zero;
   logic second_zero;

   assign first_missing  = (first_allele == ALLELE_MISSING);
   assign second_missing = (second_allele == ALLELE_MISSING);
   assign first_zero     = (first_allele == '0);
   assign second_zero    = (second_allele == '0);

   always_comb begin
      if (!has_second) begin
         if (first_missing) begin
            code = CODE_MISSING;
         end else if (first_zero) begin
            code = CODE_REF;
         end else begin
            code = CODE_HET;
         end
      end else if (first_missing && second_missing) begin
         code = CODE_MISSING;
      end else if (first_zero && second_zero) begin
         code = CODE_REF;
      end else if (first_allele != second_allele) begin
         // One missing allele against a called one also lands here.
         code = CODE_HET;
      end else begin
         code = CODE_HOM_ALT;
      end
   end

endmodule

/* hdl/genotype_two_bit_packer_core.sv */
// Genotype packer: one sample per transaction in, one packed 32-bit word out per 16 samples
// or per variant end, with the variant's code sum and leading-zero count on its final word.
// The block takes one sample every clock cycle. Each sample is classified and merged into
// the word being filled in the same cycle; a finished word appears on the result port in
// the cycle after the sample that completed it and sits in a single output register, so
// input flow pauses only while that register holds a word the downstream side has not taken.
module genotype_two_bit_packer_core
   import gtpk_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [8:0] first_allele, [9] has_second, [18:10] second_allele, [23:19] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,   // last_sample
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [31:0] packed_word, [49:32] code_sum, [67:50] zero_prefix_bits, [71:68] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast    // variant_done
);

   logic [SLOT_W-1:0] slot_count_ff,   slot_count_in;
   logic [WORD_W-1:0] word_accum_ff,   word_accum_in;
   logic [STAT_W-1:0] running_sum_ff,  running_sum_in;
   logic [STAT_W-1:0] prefix_accum_ff, prefix_accum_in;
   logic              seen_nonzero_ff, seen_nonzero_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff,  rsp_data_in;
   logic                  rsp_last_ff,  rsp_last_in;

   logic signed [ALLELE_W-1:0] first_allele;
   logic                       has_second;
   logic signed [ALLELE_W-1:0] second_allele;
   gt_code_type                code;

   logic              req_fire;
   logic              emit;
   logic [WORD_W-1:0] word_new;
   logic [STAT_W:0]   sum_wide;
   logic [STAT_W-1:0] sum_new;
   logic [LZ_W-1:0]   word_lz;
   logic [STAT_W:0]   prefix_wide;
   logic [STAT_W-1:0] prefix_new;

   function automatic logic [LZ_W-1:0] lead_zeros(input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] v;
      logic [LZ_W-1:0]   n;
      v = w;
      n = '0;
      if (w == '0) begin
         n = LZ_W'(WORD_W);
      end else begin
         if (v[31:16] == '0) begin
            n = n + LZ_W'(16);
            v = v << 16;
         end
         if (v[31:24] == '0) begin
            n = n + LZ_W'(8);
            v = v << 8;
         end
         if (v[31:28] == '0) begin
            n = n + LZ_W'(4);
            v = v << 4;
         end
         if (v[31:30] == '0) begin
            n = n + LZ_W'(2);
            v = v << 2;
         end
         if (!v[31]) begin
            n = n + LZ_W'(1);
         end
      end
      return n;
   endfunction

   assign first_allele  = req_tdata[8:0];
   assign has_second    = req_tdata[9];
   assign second_allele = req_tdata[18:10];

   gtpk_classify u_classify (
      .first_allele  (first_allele),
      .has_second    (has_second),
      .second_allele (second_allele),
      .code          (code)
   );

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign emit       = (slot_count_ff == '1) || req_tlast;

   // The first sample of a word lands in bits 31..30.
   assign word_new = word_accum_ff | ({code, {(WORD_W-CODE_W){1'b0}}} >> {slot_count_ff, 1'b0});

   assign sum_wide = {1'b0, running_sum_ff} + (STAT_W+1)'(code);
   assign sum_new  = (sum_wide > (STAT_W+1)'(SUM_LIMIT)) ? STAT_W'(SUM_LIMIT)
                                                          : sum_wide[STAT_W-1:0];

   assign word_lz     = lead_zeros(word_new);
   assign prefix_wide = {1'b0, prefix_accum_ff} + (STAT_W+1)'(word_lz);

   // Once a nonzero word has gone out, the leading-zero run is over.
   always_comb begin
      if (seen_nonzero_ff) begin
         prefix_new = prefix_accum_ff;
      end else if (prefix_wide > (STAT_W+1)'(PREFIX_LIMIT)) begin
         prefix_new = STAT_W'(PREFIX_LIMIT);
      end else begin
         prefix_new = prefix_wide[STAT_W-1:0];
      end
   end

   always_comb begin
      slot_count_in   = slot_count_ff;
      word_accum_in   = word_accum_ff;
      running_sum_in  = running_sum_ff;
      prefix_accum_in = prefix_accum_ff;
      seen_nonzero_in = seen_nonzero_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_data_in     = rsp_data_ff;
      rsp_last_in     = rsp_last_ff;
      if (req_fire) begin
         if (!emit) begin
            slot_count_in  = slot_count_ff + SLOT_W'(1);
            word_accum_in  = word_new;
            running_sum_in = sum_new;
         end else begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = req_tlast;
            if (req_tlast) begin
               rsp_data_in     = {4'b0, prefix_new, sum_new, word_new};
               slot_count_in   = '0;
               word_accum_in   = '0;
               running_sum_in  = '0;
               prefix_accum_in = '0;
               seen_nonzero_in = 1'b0;
            end else begin
               rsp_data_in     = {4'b0, {STAT_W{1'b0}}, {STAT_W{1'b0}}, word_new};
               slot_count_in   = '0;
               word_accum_in   = '0;
               running_sum_in  = sum_new;
               prefix_accum_in = prefix_new;
               seen_nonzero_in = seen_nonzero_ff || (word_new != '0);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff   <= '0;
         word_accum_ff   <= '0;
         running_sum_ff  <= '0;
         prefix_accum_ff <= '0;
         seen_nonzero_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         slot_count_ff   <= slot_count_in;
         word_accum_ff   <= word_accum_in;
         running_sum_ff  <= running_sum_in;
         prefix_accum_ff <= prefix_accum_in;
         seen_nonzero_ff <= seen_nonzero_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* hdl/gtpk_checker.sv */
// Port-level checks for the genotype packer and the bind that attaches them.
module gtpk_checker
   import gtpk_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  req_tlast,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   // A stalled result transaction keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // The end of a variant always produces its final word in the next cycle.
   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> rsp_tvalid && rsp_tlast)
      else $error("variant end did not produce a final word");

   // Statistics are zero on words that do not close a variant.
   a_mid_stats_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[RSP_DATA_W-1:WORD_W] == '0)
      else $error("statistics on a non-final word");

   // The single output register cannot take a new sample while it is stalled.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input accepted while result stalled");

   // Both statistics respect their saturation limits.
   a_stat_limits: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[49:32] <= STAT_W'(SUM_LIMIT))
                  && (rsp_tdata[67:50] <= STAT_W'(PREFIX_LIMIT)))
      else $error("statistic above its limit");

endmodule

bind genotype_two_bit_packer_core gtpk_checker u_gtpk_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

/* tb/sv/tb_genotype_two_bit_packer_core.sv */
// Self-checking testbench for the genotype two-bit packer core.
`timescale 1ns / 1ps

module tb_genotype_two_bit_packer_core;
   import gtpk_pkg::*;

   typedef struct packed {
      logic signed [ALLELE_W-1:0] first;
      logic                       has_second;
      logic signed [ALLELE_W-1:0] second;
      logic                       last;
   } sample_type;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              done;
      logic [STAT_W-1:0] sum;
      logic [STAT_W-1:0] prefix;
   } packed_word_type;

   typedef enum int {KIND_REF, KIND_HET, KIND_HOM, KIND_MISSING, KIND_RAW} sample_kind_type;

   localparam int RANDOM_ITEMS = 450;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [8:0] first_allele, [9] has_second, [18:10] second_allele, [23:19] zero
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tlast = 1'b0;   // last_sample
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [31:0] packed_word, [49:32] code_sum, [67:50] zero_prefix_bits, [71:68] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;          // variant_done

   sample_type      pending_samples[$];
   packed_word_type expected_words[$];
   sample_type      in_flight;
   packed_word_type oldest_word;
   int              items_queued = 0;
   int              mismatches = 0;
   int              burst_left = 0;
   int              gap_left = 0;
   int              stall_tick = 0;

   // Shadow of the packer state.
   logic [SLOT_W-1:0] slot_fill = '0;
   logic [WORD_W-1:0] word_fill = '0;
   logic [STAT_W-1:0] code_total = '0;
   logic [STAT_W-1:0] prefix_zeros = '0;
   logic              prefix_closed = 1'b0;

   genotype_two_bit_packer_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic gt_code_type classify_sample(input sample_type s);
      if (!s.has_second) begin
         if (s.first == ALLELE_MISSING) return CODE_MISSING;
         return (s.first == 0) ? CODE_REF : CODE_HET;
      end
      if (s.first == ALLELE_MISSING && s.second == ALLELE_MISSING) return CODE_MISSING;
      if (s.first == 0 && s.second == 0) return CODE_REF;
      if (s.first != s.second) return CODE_HET;
      return CODE_HOM_ALT;
   endfunction

   function automatic int count_leading_zeros(input logic [WORD_W-1:0] w);
      int n;
      n = 0;
      for (int i = WORD_W - 1; i >= 0 && !w[i]; i--) n++;
      return n;
   endfunction

   // Merges one accepted sample into the shadow word and queues the word it completes.
   function automatic void pack_sample(input sample_type s);
      gt_code_type     code;
      int              total;
      packed_word_type r;
      code = classify_sample(s);
      word_fill = word_fill | (32'(code) << (30 - 2 * int'(slot_fill)));
      total = int'(code_total) + int'(code);
      code_total = STAT_W'((total > SUM_LIMIT) ? SUM_LIMIT : total);
      if (slot_fill != 4'd15 && !s.last) begin
         slot_fill = slot_fill + 4'd1;
         return;
      end
      // Leading zeros stop accumulating once a nonzero word has gone out.
      if (!prefix_closed) begin
         total = int'(prefix_zeros) + count_leading_zeros(word_fill);
         prefix_zeros = STAT_W'((total > PREFIX_LIMIT) ? PREFIX_LIMIT : total);
         if (word_fill != '0) prefix_closed = 1'b1;
      end
      r.word = word_fill;
      r.done = s.last;
      r.sum = s.last ? code_total : '0;
      r.prefix = s.last ? prefix_zeros : '0;
      expected_words.push_back(r);
      word_fill = '0;
      slot_fill = '0;
      if (s.last) begin
         code_total = '0;
         prefix_zeros = '0;
         prefix_closed = 1'b0;
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      if (mismatches <= 100)
         $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
   endtask

   task automatic push_sample(input logic signed [ALLELE_W-1:0] a, input logic diploid,
                              input logic signed [ALLELE_W-1:0] b, input logic last);
      sample_type s;
      s.first = a;
      s.has_second = diploid;
      s.second = b;
      s.last = last;
      pending_samples.push_back(s);
      items_queued++;
   endtask

   function automatic sample_type make_sample(input sample_kind_type kind);
      sample_type s;
      s.has_second = 1'($urandom_range(0, 1));
      s.first = 9'($urandom);
      s.second = 9'($urandom);
      s.last = 1'b0;
      case (kind)
         KIND_REF: begin
            s.first = '0;
            if (s.has_second) s.second = '0;
         end
         KIND_HET: begin
            if (s.has_second) begin
               if (s.second == s.first) s.second = s.first + 9'sd1;
            end else if (s.first == 0 || s.first == ALLELE_MISSING) begin
               s.first = 9'sd7;
            end
         end
         KIND_HOM: begin
            s.has_second = 1'b1;
            if (s.first == 0 || s.first == ALLELE_MISSING) s.first = -9'sd3;
            s.second = s.first;
         end
         KIND_MISSING: begin
            s.first = ALLELE_MISSING;
            if (s.has_second) s.second = ALLELE_MISSING;
         end
         default: ;
      endcase
      return s;
   endfunction

   // Variant of random length and flavor; zero-leading variants exercise the prefix count.
   task automatic add_random_variant();
      int              len;
      int              lead;
      int              flavor;
      int              pick;
      sample_kind_type kind;
      sample_type      s;
      pick = $urandom_range(0, 19);
      if (pick < 13) len = $urandom_range(1, 40);
      else if (pick < 18) len = $urandom_range(41, 100);
      else len = 16 * $urandom_range(1, 4);
      flavor = $urandom_range(0, 3);
      lead = (flavor == 0) ? $urandom_range(0, len) : 0;
      for (int i = 0; i < len; i++) begin
         if (i < lead) kind = KIND_REF;
         else if (flavor == 2) kind = KIND_RAW;
         else if (flavor == 3 && $urandom_range(0, 3) != 0) kind = KIND_MISSING;
         else kind = sample_kind_type'($urandom_range(0, 4));
         s = make_sample(kind);
         s.last = (i == len - 1);
         pending_samples.push_back(s);
         items_queued++;
      end
   endtask

   // Checked away from the rising edge so the driver and monitor updates have settled.
   task automatic wait_drained();
      @(negedge clock);
      while (pending_samples.size() != 0 || req_tvalid || expected_words.size() != 0)
         @(negedge clock);
   endtask

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tlast <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) pack_sample(in_flight);
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
               in_flight = pending_samples.pop_front();
               req_tdata <= {5'b0, in_flight.second, in_flight.has_second, in_flight.first};
               req_tlast <= in_flight.last;
               req_tvalid <= 1'b1;
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 64);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: ready pattern cycles through free-running, random, sparse and long stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               report_mismatch("transaction with no expected word", rsp_tdata[31:0], '0);
            end else begin
               oldest_word = expected_words.pop_front();
               if (rsp_tdata[31:0] !== oldest_word.word)
                  report_mismatch("packed_word", rsp_tdata[31:0], oldest_word.word);
               if (rsp_tlast !== oldest_word.done)
                  report_mismatch("variant_done", 32'(rsp_tlast), 32'(oldest_word.done));
               if (rsp_tdata[49:32] !== oldest_word.sum)
                  report_mismatch("code_sum", 32'(rsp_tdata[49:32]), 32'(oldest_word.sum));
               if (rsp_tdata[67:50] !== oldest_word.prefix)
                  report_mismatch("zero_prefix_bits", 32'(rsp_tdata[67:50]),
                                  32'(oldest_word.prefix));
               if (rsp_tdata[71:68] !== 4'b0)
                  report_mismatch("padding bits", 32'(rsp_tdata[71:68]), '0);
            end
         end
         stall_tick++;
         case ((stall_tick / 97) % 4)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= (stall_tick % 5 == 0);
            default: rsp_tready <= (stall_tick % 23 >= 15);
         endcase
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Single haploid reference sample: one padded all-zero word.
      push_sample(9'sd0, 1'b0, ALLELE_MISSING, 1'b1);
      // Every code, odd negative indices, one missing allele, haploid with junk second.
      push_sample(9'sd255, 1'b0, 9'sd0, 1'b0);
      push_sample(ALLELE_MISSING, 1'b0, 9'sd255, 1'b0);
      push_sample(-9'sd2, 1'b0, 9'sd0, 1'b0);
      push_sample(9'h100, 1'b1, 9'h100, 1'b0);
      push_sample(ALLELE_MISSING, 1'b1, ALLELE_MISSING, 1'b0);
      push_sample(ALLELE_MISSING, 1'b1, 9'sd0, 1'b0);
      push_sample(9'sd0, 1'b1, 9'sd0, 1'b0);
      push_sample(9'sd255, 1'b1, 9'sd255, 1'b1);
      // Sixteen reference samples: the word fills on the same sample that ends the variant.
      for (int i = 0; i < 16; i++) push_sample(9'sd0, 1'(i % 2), 9'sd0, 1'(i == 15));

      // Hold the sender until the block has drained.
      wait_drained();

      while (items_queued < RANDOM_ITEMS) add_random_variant();

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("genotype_two_bit_packer_core test passed");
      end else begin
         $display("genotype_two_bit_packer_core test failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("genotype_two_bit_packer_core test failed");
      $finish;
   end

endmodule

/* genotype_two_bit_packer_core.f */
hdl/gtpk_pkg.sv
hdl/gtpk_classify.sv
hdl/genotype_two_bit_packer_core.sv
hdl/gtpk_checker.sv
tb/sv/tb_genotype_two_bit_packer_core.sv
